// File: hdl/srb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types and constants of the sample ring buffer.
// ----------------------------------------------------------------------------
package srb_pkg;

    // Buffer geometry (DEPTH is a power of two, pointers wrap by truncation)
    localparam int DEPTH    = 1024;
    localparam int MAX_READ = 64;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int RD_W     = $clog2(MAX_READ + 1);

    // Payload widths fixed by the interface
    localparam int KIND_W   = 3;
    localparam int LEN_W    = 11;
    localparam int SMP_W    = 16;
    localparam int TOT_W    = 32;

    // Command queue between front and back
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // Kind codes on the command channel
    localparam logic [KIND_W-1:0] KIND_WSTART = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WELEM  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    // Classified operation
    typedef enum logic [2:0] {
        OP_WSTART,
        OP_WELEM,
        OP_READ,
        OP_REMOVE,
        OP_CLEAR,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [LEN_W-1:0]   length;
        logic               forced;
        logic signed [SMP_W-1:0] sample;
    } cmd_t;

    // Sample store access from the back end
    typedef struct packed {
        logic               we;
        logic [PTR_W-1:0]   waddr;
        logic [SMP_W-1:0]   wdata;
        logic               re;
        logic [PTR_W-1:0]   raddr;
    } ram_req_t;

    // Back end sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_RD_EMIT
    } state_t;

endpackage
`default_nettype wire

// File: hdl/srb_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_cmd_if
// Command channel: valid/ready with the operation payload.
// ----------------------------------------------------------------------------
interface srb_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [srb_pkg::KIND_W-1:0]            kind;
    logic [srb_pkg::LEN_W-1:0]             length;
    logic                                  forced;
    logic signed [srb_pkg::SMP_W-1:0]      sample_in;

    modport source (output valid, kind, length, forced, sample_in, input ready);
    modport sink   (input valid, kind, length, forced, sample_in, output ready);
endinterface
`default_nettype wire

// File: hdl/srb_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_res_if
// Result channel: valid/ready with the result payload.
// ----------------------------------------------------------------------------
interface srb_res_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  ok;
    logic signed [srb_pkg::SMP_W-1:0]      sample_out;
    logic                                  last;
    logic [srb_pkg::LEN_W-1:0]             fill_level;
    logic [srb_pkg::TOT_W-1:0]             total_written;

    modport source (output valid, ok, sample_out, last, fill_level, total_written,
                    input ready);
    modport sink   (input valid, ok, sample_out, last, fill_level, total_written,
                    output ready);
endinterface
`default_nettype wire

// File: hdl/srb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module srb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]                rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, output holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: hdl/srb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_front
// Accepts command beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module srb_front (
    input  wire logic       clk,
    input  wire logic       rst_n,
    srb_cmd_if.sink         cmd,
    output logic            q_valid,
    output srb_pkg::cmd_t   q_cmd,
    input  wire logic       q_pop
);

    srb_pkg::cmd_t                  q_mem_reg [srb_pkg::QDEPTH];
    logic [srb_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [srb_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [srb_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;
    srb_pkg::cmd_t                  cls;
    logic                           push;

    // Classify the incoming beat; read lengths are capped here
    always_comb
    begin
        cls.length = cmd.length;
        cls.forced = cmd.forced;
        cls.sample = cmd.sample_in;
        case (cmd.kind)
            srb_pkg::KIND_WSTART: cls.op = srb_pkg::OP_WSTART;
            srb_pkg::KIND_WELEM:  cls.op = srb_pkg::OP_WELEM;
            srb_pkg::KIND_READ:
            begin
                cls.op = srb_pkg::OP_READ;
                if (cmd.length > srb_pkg::LEN_W'(srb_pkg::MAX_READ))
                begin
                    cls.length = srb_pkg::LEN_W'(srb_pkg::MAX_READ);
                end
            end
            srb_pkg::KIND_REMOVE: cls.op = srb_pkg::OP_REMOVE;
            srb_pkg::KIND_CLEAR:  cls.op = srb_pkg::OP_CLEAR;
            default:              cls.op = srb_pkg::OP_BAD;
        endcase
    end

    // Queue control
    assign cmd.ready = (cnt_reg != srb_pkg::QCNT_W'(srb_pkg::QDEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (cnt_reg != '0);
    assign q_cmd     = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule
`default_nettype wire

// File: hdl/srb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_back
// Executes queued operations on the ring state and drives the result beats.
// ----------------------------------------------------------------------------
module srb_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    input  wire srb_pkg::cmd_t              q_cmd,
    output logic                            q_pop,
    output srb_pkg::ram_req_t               ram_req,
    input  wire logic [srb_pkg::SMP_W-1:0]  ram_rdata,
    srb_res_if.source                       res
);

    localparam logic [srb_pkg::CNT_W-1:0] FULL = srb_pkg::CNT_W'(srb_pkg::DEPTH);

    srb_pkg::state_t                state_reg, state_next;
    logic [srb_pkg::PTR_W-1:0]      rp_reg, rp_next;
    logic [srb_pkg::PTR_W-1:0]      wp_reg, wp_next;
    logic [srb_pkg::CNT_W-1:0]      held_reg, held_next;
    logic [srb_pkg::LEN_W-1:0]      blk_reg, blk_next;
    logic [srb_pkg::TOT_W-1:0]      total_reg, total_next;
    logic [srb_pkg::RD_W-1:0]       left_reg, left_next;

    logic                           res_valid_reg, res_valid_next;
    logic                           ok_reg, ok_next;
    logic [srb_pkg::SMP_W-1:0]      smp_reg, smp_next;
    logic                           last_reg, last_next;
    logic [srb_pkg::LEN_W-1:0]      fill_reg, fill_next;
    logic [srb_pkg::TOT_W-1:0]      tot_out_reg, tot_out_next;

    logic                           out_free;
    logic                           emit;
    logic [srb_pkg::CNT_W-1:0]      free_room;
    logic [srb_pkg::CNT_W-1:0]      len_c;
    logic [srb_pkg::CNT_W-1:0]      drop;

    assign out_free  = !res_valid_reg || res.ready;
    assign free_room = FULL - held_reg;
    assign len_c     = srb_pkg::CNT_W'(q_cmd.length);
    assign drop      = len_c - free_room;

    // Operation sequencer and ring state update
    always_comb
    begin
        state_next = state_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        held_next  = held_reg;
        blk_next   = blk_reg;
        total_next = total_reg;
        left_next  = left_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        ok_next    = 1'b0;
        smp_next   = '0;
        last_next  = 1'b1;
        ram_req    = '{we: 1'b0, waddr: wp_reg, wdata: q_cmd.sample,
                       re: 1'b0, raddr: rp_reg};

        case (state_reg)
            srb_pkg::ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    emit  = 1'b1;
                    case (q_cmd.op)
                        srb_pkg::OP_WSTART:
                        begin
                            blk_next = '0;
                            if (len_c <= free_room)
                            begin
                                ok_next    = 1'b1;
                                total_next = total_reg + srb_pkg::TOT_W'(q_cmd.length);
                                blk_next   = q_cmd.length;
                            end
                            else if (q_cmd.forced && len_c <= FULL)
                            begin
                                // Drop the oldest samples to make room
                                ok_next    = 1'b1;
                                rp_next    = rp_reg + drop[srb_pkg::PTR_W-1:0];
                                held_next  = FULL - len_c;
                                total_next = total_reg + srb_pkg::TOT_W'(q_cmd.length);
                                blk_next   = q_cmd.length;
                            end
                        end
                        srb_pkg::OP_WELEM:
                        begin
                            if (blk_reg != '0 && held_reg < FULL)
                            begin
                                ok_next    = 1'b1;
                                ram_req.we = 1'b1;
                                wp_next    = wp_reg + 1'b1;
                                held_next  = held_reg + 1'b1;
                                blk_next   = blk_reg - 1'b1;
                            end
                        end
                        srb_pkg::OP_READ:
                        begin
                            if (len_c <= held_reg)
                            begin
                                ok_next = 1'b1;
                                if (q_cmd.length != '0)
                                begin
                                    // Samples follow, no status beat
                                    emit       = 1'b0;
                                    ram_req.re = 1'b1;
                                    left_next  = q_cmd.length[srb_pkg::RD_W-1:0];
                                    state_next = srb_pkg::ST_RD_WAIT;
                                end
                            end
                        end
                        srb_pkg::OP_REMOVE:
                        begin
                            if (len_c <= held_reg)
                            begin
                                ok_next   = 1'b1;
                                rp_next   = rp_reg + q_cmd.length[srb_pkg::PTR_W-1:0];
                                held_next = held_reg - len_c;
                            end
                        end
                        srb_pkg::OP_CLEAR:
                        begin
                            ok_next   = 1'b1;
                            held_next = '0;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            srb_pkg::ST_RD_WAIT:
            begin
                state_next = srb_pkg::ST_RD_EMIT;
            end
            srb_pkg::ST_RD_EMIT:
            begin
                if (out_free)
                begin
                    // One sample beat; fetch the next one behind it
                    emit      = 1'b1;
                    ok_next   = 1'b1;
                    smp_next  = ram_rdata;
                    last_next = (left_reg == srb_pkg::RD_W'(1));
                    rp_next   = rp_reg + 1'b1;
                    held_next = held_reg - 1'b1;
                    left_next = left_reg - 1'b1;
                    if (left_reg == srb_pkg::RD_W'(1))
                    begin
                        state_next = srb_pkg::ST_IDLE;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = rp_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = srb_pkg::ST_IDLE;
            end
        endcase

        // Empty buffer: both pointers return to zero
        if (held_next == '0)
        begin
            rp_next = '0;
            wp_next = '0;
        end
    end

    // Result register
    always_comb
    begin
        res_valid_next = res_valid_reg && !res.ready;
        fill_next      = fill_reg;
        tot_out_next   = tot_out_reg;
        if (emit)
        begin
            res_valid_next = 1'b1;
            fill_next      = held_next;
            tot_out_next   = total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srb_pkg::ST_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            held_reg      <= '0;
            blk_reg       <= '0;
            total_reg     <= '0;
            left_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            held_reg      <= held_next;
            blk_reg       <= blk_next;
            total_reg     <= total_next;
            left_reg      <= left_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ok_reg   <= ok_next;
            smp_reg  <= smp_next;
            last_reg <= last_next;
        end
        fill_reg    <= fill_next;
        tot_out_reg <= tot_out_next;
    end

    assign res.valid         = res_valid_reg;
    assign res.ok            = ok_reg;
    assign res.sample_out    = smp_reg;
    assign res.last          = last_reg;
    assign res.fill_level    = fill_reg;
    assign res.total_written = tot_out_reg;

`ifndef NO_ASSERTIONS
    // Fill never exceeds the capacity
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= FULL)
        else $error("held count above capacity");

    // Empty buffer keeps both pointers at zero
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg == '0 |-> (rp_reg == '0 && wp_reg == '0))
        else $error("pointers not reset on empty buffer");

    // Pointer distance matches the fill modulo the depth
    a_ptr_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg - rp_reg) == held_reg[srb_pkg::PTR_W-1:0])
        else $error("pointer distance disagrees with fill");

    // A read in progress always has samples left to send
    a_read_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != srb_pkg::ST_IDLE |-> (left_reg != '0 && held_reg >= left_reg))
        else $error("read sequence without samples");
`endif

endmodule
`default_nettype wire

// File: hdl/sample_ring_buffer_with_overwrite.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sample_ring_buffer_with_overwrite
// Ring buffer of 16-bit samples driven by block write, read, remove and clear.
// ----------------------------------------------------------------------------
// Every command beat gives one result beat, except a successful read of N > 0
// samples, which gives N sample beats with last set on the final one. Commands
// pass through a two-entry queue, so the command side keeps moving while a
// result waits, until the queue is full. Write start, write element, remove,
// clear and invalid kinds finish in the back end's idle state; a read goes
// through RD_WAIT to RD_EMIT for the sample RAM's registered read, then gives
// one sample per cycle while results are taken. No clearing pass after reset.
module sample_ring_buffer_with_overwrite (
    input  wire logic   clk,
    input  wire logic   rst_n,
    srb_cmd_if.sink     cmd,
    srb_res_if.source   res
);

    logic                       q_valid;
    srb_pkg::cmd_t              q_cmd;
    logic                       q_pop;
    srb_pkg::ram_req_t          ram_req;
    logic [srb_pkg::SMP_W-1:0]  ram_rdata;

    // Front end: accept and classify
    srb_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    // Back end: ring state and results
    srb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res       (res)
    );

    // Sample store
    srb_ram #(
        .WIDTH (srb_pkg::SMP_W),
        .DEPTH (srb_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire
